[rtl/core/sbq_pkg.sv]
// Shared types and constants for the semaphore blocked-queue table.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package sbq_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int KEY_BITS    = 32;
    localparam int PROC_W      = 5;
    localparam int NPROC       = 1 << PROC_W;
    localparam int DIDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [DIDX_W-1:0]   didx_t;
    typedef logic [PROC_W-1:0]   pidx_t;

    typedef enum logic [1:0] {
        ACT_BLOCK  = 2'd0,
        ACT_RMHEAD = 2'd1,
        ACT_RMPROC = 2'd2,
        ACT_PEEK   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_NULL     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_RESOLVE,
        S_HEAD,
        S_APPEND,
        S_NEWD,
        S_UNLINK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic    load_in;
        logic    load_pdesc;
        logic    scan_clr;
        logic    scan_step;
        logic    load_head;
        logic    do_append;
        logic    do_newd;
        logic    do_unlink;
        logic    res_load;
        logic    res_valid;
        status_t res_status;
    } cmd_t;

    typedef struct packed {
        action_t act;
        logic    key_zero;
        logic    blocked;
        logic    scan_hit;
        logic    scan_last;
        logic    found;
        logic    free_found;
    } sts_t;

endpackage

`default_nettype wire

[rtl/core/sbq_ctrl.sv]
// Controller state machine for the semaphore blocked-queue table.
// Depends on sbq_pkg; drives commands to sbq_dpath and reads its status.
`default_nettype none

module sbq_ctrl
    import sbq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.act == ACT_RMPROC)
                begin
                    state_next = sts.blocked ? S_UNLINK : S_OUT;
                end
                else if (sts.key_zero || (sts.act == ACT_BLOCK && sts.blocked))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_hit || sts.scan_last)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (sts.act == ACT_BLOCK)
                begin
                    if (sts.found)
                    begin
                        state_next = S_APPEND;
                    end
                    else if (sts.free_found)
                    begin
                        state_next = S_NEWD;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    state_next = sts.found ? S_HEAD : S_OUT;
                end
            end
            S_HEAD:
            begin
                state_next = (sts.act == ACT_PEEK) ? S_OUT : S_UNLINK;
            end
            S_APPEND, S_NEWD, S_UNLINK:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            S_DECODE:
            begin
                if (sts.act == ACT_RMPROC)
                begin
                    if (sts.blocked)
                    begin
                        cmd.load_pdesc = 1'b1;
                    end
                    else
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_NOTFOUND;
                    end
                end
                else if (sts.key_zero)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NULL;
                end
                else if (sts.act == ACT_BLOCK && sts.blocked)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NOTFOUND;
                end
                else
                begin
                    cmd.scan_clr = 1'b1;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            S_RESOLVE:
            begin
                if (sts.act == ACT_BLOCK)
                begin
                    if (!sts.found && !sts.free_found)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_FULL;
                    end
                end
                else if (sts.found)
                begin
                    cmd.load_head = 1'b1;
                end
                else
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NOTFOUND;
                end
            end
            S_HEAD:
            begin
                if (sts.act == ACT_PEEK)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_valid  = 1'b1;
                    cmd.res_status = ST_OK;
                end
            end
            S_APPEND:
            begin
                cmd.do_append  = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
            end
            S_NEWD:
            begin
                cmd.do_newd    = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
            end
            S_UNLINK:
            begin
                cmd.do_unlink  = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_valid  = 1'b1;
                cmd.res_status = ST_OK;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/sbq_dpath.sv]
// Datapath for the semaphore blocked-queue table: descriptor table, process
// links, the key scan and the result register. Depends on sbq_pkg.
`default_nettype none

module sbq_dpath
    import sbq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] sem_key,
    input  wire logic [4:0]  proc_id,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    output logic [4:0]       proc_out,
    output logic             proc_valid,
    output logic [1:0]       status
);

    action_t act_reg;
    key_t    key_reg;
    pidx_t   p_reg;
    didx_t   d_reg;
    didx_t   idx_reg;
    logic    found_reg;
    logic    free_reg;
    didx_t   free_idx_reg;

    key_t    dkey_reg [MAX_ENTRIES];
    pidx_t   head_reg [MAX_ENTRIES];
    pidx_t   tail_reg [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] in_use_reg;

    pidx_t   fwd_reg   [NPROC];
    pidx_t   bwd_reg   [NPROC];
    didx_t   pdesc_reg [NPROC];
    logic [NPROC-1:0] blocked_reg;

    pidx_t   pout_reg;
    logic    pvalid_reg;
    status_t status_reg;

    pidx_t h;
    pidx_t t;
    pidx_t nx;
    pidx_t pv;
    logic  hit;

    assign h   = head_reg[d_reg];
    assign t   = tail_reg[d_reg];
    assign nx  = fwd_reg[p_reg];
    assign pv  = bwd_reg[p_reg];
    assign hit = in_use_reg[idx_reg] && (dkey_reg[idx_reg] == key_reg);

    assign sts.act        = act_reg;
    assign sts.key_zero   = (key_reg == '0);
    assign sts.blocked    = blocked_reg[p_reg];
    assign sts.scan_hit   = hit;
    assign sts.scan_last  = (idx_reg == DIDX_W'(MAX_ENTRIES - 1));
    assign sts.found      = found_reg;
    assign sts.free_found = free_reg;

    assign proc_out   = pout_reg;
    assign proc_valid = pvalid_reg;
    assign status     = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg  <= '0;
            blocked_reg <= '0;
        end
        else
        begin
            if (cmd.do_newd)
            begin
                in_use_reg[free_idx_reg] <= 1'b1;
                blocked_reg[p_reg]       <= 1'b1;
            end
            if (cmd.do_append)
            begin
                blocked_reg[p_reg] <= 1'b1;
            end
            if (cmd.do_unlink)
            begin
                blocked_reg[p_reg] <= 1'b0;
                // The last waiter leaving frees the descriptor.
                if (h == p_reg && t == p_reg)
                begin
                    in_use_reg[d_reg] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            act_reg <= action_t'(action);
            key_reg <= key_t'(sem_key);
            p_reg   <= proc_id;
        end
        if (cmd.load_pdesc)
        begin
            d_reg <= pdesc_reg[p_reg];
        end
        if (cmd.scan_clr)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
        end
        if (cmd.scan_step)
        begin
            if (hit)
            begin
                found_reg <= 1'b1;
                d_reg     <= idx_reg;
            end
            if (!in_use_reg[idx_reg] && !free_reg)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= idx_reg;
            end
            idx_reg <= idx_reg + DIDX_W'(1);
        end
        if (cmd.load_head)
        begin
            p_reg <= h;
        end
        if (cmd.do_append)
        begin
            fwd_reg[t]       <= p_reg;
            bwd_reg[p_reg]   <= t;
            tail_reg[d_reg]  <= p_reg;
            pdesc_reg[p_reg] <= d_reg;
        end
        if (cmd.do_newd)
        begin
            dkey_reg[free_idx_reg] <= key_reg;
            head_reg[free_idx_reg] <= p_reg;
            tail_reg[free_idx_reg] <= p_reg;
            pdesc_reg[p_reg]       <= free_idx_reg;
        end
        if (cmd.do_unlink)
        begin
            if (h == p_reg && t == p_reg)
            begin
                head_reg[d_reg] <= h;
            end
            else if (h == p_reg)
            begin
                head_reg[d_reg] <= nx;
            end
            else if (t == p_reg)
            begin
                tail_reg[d_reg] <= pv;
            end
            else
            begin
                fwd_reg[pv] <= nx;
                bwd_reg[nx] <= pv;
            end
        end
        if (cmd.res_load)
        begin
            pout_reg   <= cmd.res_valid ? p_reg : '0;
            pvalid_reg <= cmd.res_valid;
            status_reg <= cmd.res_status;
        end
    end

    a_newd_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_newd |=> in_use_reg[$past(free_idx_reg)])
        else $error("new descriptor not marked in use");

    a_append_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_append |-> (found_reg && in_use_reg[d_reg]))
        else $error("append without a matching descriptor");

    a_unlink_needs_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_unlink |-> (blocked_reg[p_reg] && in_use_reg[d_reg]))
        else $error("unlink of a process that is not queued");

endmodule

`default_nettype wire

[rtl/core/semaphore_blocked_queue_table_unit.sv]
// Top level of the semaphore blocked-queue table.
// Depends on sbq_pkg, sbq_ctrl and sbq_dpath.
//
//  Channel | Handshake           | Beat fields
//  --------+---------------------+------------------------------
//  input   | in_valid / in_stall | action, sem_key, proc_id
//  output  | out_valid/out_stall | proc_out, proc_valid, status
//
// One beat is taken at a time; a new one can be accepted from the cycle after
// the result beat leaves. An early rejection goes from decode straight to the
// result; when the key scan runs, it compares one key per cycle and stops at
// a hit or at the last descriptor. Reset is asynchronous, active low, and frees
// every descriptor at once. A stalled result holds its beat.
`default_nettype none

module semaphore_blocked_queue_table_unit
    import sbq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] sem_key,
    input  wire logic [4:0]  proc_id,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       proc_out,
    output logic             proc_valid,
    output logic [1:0]       status
);

    cmd_t cmd;
    sts_t sts;

    sbq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    sbq_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .action     (action),
        .sem_key    (sem_key),
        .proc_id    (proc_id),
        .cmd        (cmd),
        .sts        (sts),
        .proc_out   (proc_out),
        .proc_valid (proc_valid),
        .status     (status)
    );

endmodule

`default_nettype wire

[bench/semaphore_blocked_queue_table_unit_tb.sv]
// Self-checking testbench for the semaphore blocked-queue table.
// Depends on sbq_pkg and semaphore_blocked_queue_table_unit; predicts each result beat
// with a behavioral copy of the descriptor table and per-descriptor wait queues.
`timescale 1ns / 1ps

module semaphore_blocked_queue_table_unit_tb;
    import sbq_pkg::*;

    typedef struct packed {
        logic [4:0] pid;
        logic       pvalid;
        status_t    st;
    } sem_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [31:0] sem_key;
    logic [4:0]  proc_id;
    logic        out_valid;
    logic        out_stall;
    logic [4:0]  proc_out;
    logic        proc_valid;
    logic [1:0]  status;

    semaphore_blocked_queue_table_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .sem_key(sem_key), .proc_id(proc_id),
        .out_valid(out_valid), .out_stall(out_stall),
        .proc_out(proc_out), .proc_valid(proc_valid), .status(status)
    );

    // Behavioral table: one FIFO of process ids per descriptor.
    logic [31:0] tbl_key [MAX_ENTRIES];
    bit          tbl_used [MAX_ENTRIES];
    logic [4:0]  tbl_waiters [MAX_ENTRIES][$];
    logic [31:0] waits_on [NPROC];

    sem_result_t pending_results[$];
    int          error_count;
    longint      cycle_count;
    bit          hold_off;
    int          idle_pct;
    logic [31:0] key_pool [8];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int find_key(logic [31:0] k);
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (tbl_used[i] && tbl_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic int find_free_desc();
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (!tbl_used[i])
                return i;
        return -1;
    endfunction

    function automatic void drop_waiter(int d, logic [4:0] p);
        for (int i = 0; i < tbl_waiters[d].size(); i++)
            if (tbl_waiters[d][i] == p)
            begin
                tbl_waiters[d].delete(i);
                break;
            end
        if (tbl_waiters[d].size() == 0)
            tbl_used[d] = 0;
        waits_on[p] = '0;
    endfunction

    function automatic sem_result_t predict_sem(action_t a, logic [31:0] k, logic [4:0] p);
        sem_result_t r;
        int          d;
        r = '{pid: '0, pvalid: 1'b0, st: ST_OK};
        if (a == ACT_RMPROC)
        begin
            d = (waits_on[p] != 0) ? find_key(waits_on[p]) : -1;
            if (d < 0)
                r.st = ST_NOTFOUND;
            else
            begin
                drop_waiter(d, p);
                r.pid = p;
                r.pvalid = 1'b1;
            end
        end
        else if (k == 0)
            r.st = ST_NULL;
        else if (a == ACT_BLOCK)
        begin
            if (waits_on[p] != 0)
                r.st = ST_NOTFOUND;
            else
            begin
                d = find_key(k);
                if (d < 0)
                begin
                    d = find_free_desc();
                    if (d >= 0)
                    begin
                        tbl_used[d] = 1;
                        tbl_key[d] = k;
                        tbl_waiters[d] = {};
                    end
                end
                if (d < 0)
                    r.st = ST_FULL;
                else
                begin
                    tbl_waiters[d].push_back(p);
                    waits_on[p] = k;
                end
            end
        end
        else
        begin
            d = find_key(k);
            if (d < 0)
                r.st = ST_NOTFOUND;
            else
            begin
                r.pid = tbl_waiters[d][0];
                r.pvalid = 1'b1;
                if (a == ACT_RMHEAD)
                    drop_waiter(d, r.pid);
            end
        end
        return r;
    endfunction

    // Returns at the falling edge after the beat is taken; the next call or
    // drain() decides what in_valid does from there.
    task automatic send_beat(action_t a, logic [31:0] k, logic [4:0] p);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= a;
        sem_key  <= k;
        proc_id  <= p;
        pending_results.push_back(predict_sem(a, k, p));
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (MAX_ENTRIES + 10) @(negedge clk);
    endtask

    // Result checker, sampled at the rising edge.
    always @(posedge clk)
    begin
        sem_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat pid=%0d valid=%0d status=%0d",
                       proc_out, proc_valid, status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (proc_out !== want.pid)
                begin
                    $error("proc_out: expected %0d, got %0d", want.pid, proc_out);
                    error_count++;
                end
                if (proc_valid !== want.pvalid)
                begin
                    $error("proc_valid: expected %0d, got %0d", want.pvalid, proc_valid);
                    error_count++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall, with an optional long hold-off.
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 2000000)
        begin
            $display("semaphore_blocked_queue_table_unit_tb: errors");
            $finish;
        end
    end

    function automatic logic [31:0] pick_key();
        return key_pool[$urandom_range(7)];
    endfunction

    task automatic test_directed();
        send_beat(ACT_BLOCK, 32'd0, 5'd0);
        send_beat(ACT_RMHEAD, 32'd0, 5'd31);
        send_beat(ACT_PEEK, 32'd0, 5'd0);
        send_beat(ACT_RMHEAD, 32'hFFFF_FFFF, 5'd0);
        send_beat(ACT_PEEK, 32'hFFFF_FFFF, 5'd0);
        send_beat(ACT_RMPROC, 32'h1234, 5'd31);
        send_beat(ACT_BLOCK, 32'hFFFF_FFFF, 5'd31);
        send_beat(ACT_BLOCK, 32'hFFFF_FFFF, 5'd0);
        send_beat(ACT_BLOCK, 32'hFFFF_FFFF, 5'd7);
        send_beat(ACT_BLOCK, 32'h0000_0001, 5'd31);
        send_beat(ACT_PEEK, 32'hFFFF_FFFF, 5'd0);
        send_beat(ACT_RMPROC, 32'h0, 5'd0);
        send_beat(ACT_RMHEAD, 32'hFFFF_FFFF, 5'd0);
        send_beat(ACT_RMHEAD, 32'hFFFF_FFFF, 5'd0);
        send_beat(ACT_PEEK, 32'hFFFF_FFFF, 5'd0);
        send_beat(ACT_BLOCK, 32'h0000_0001, 5'd3);
        send_beat(ACT_RMPROC, 32'h0, 5'd3);
        send_beat(ACT_RMPROC, 32'h0, 5'd3);
        drain();
    endtask

    // Fill every descriptor with its own key, then block the already waiting process 0 on one more key.
    task automatic test_table_full();
        for (int i = 0; i < 32; i++)
            send_beat(ACT_BLOCK, 32'hA000_0000 + i, i[4:0]);
        send_beat(ACT_BLOCK, 32'h5555_AAAA, 5'd0);
        for (int i = 0; i < 32; i++)
            send_beat(ACT_RMPROC, 32'h0, i[4:0]);
        drain();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 30; i++)
                send_beat(action_t'($urandom_range(3)), pick_key(), 5'($urandom()));
        join
        drain();
    endtask

    task automatic test_random(int n, int pct);
        action_t     a;
        logic [31:0] k;
        idle_pct = pct;
        for (int i = 0; i < n; i++)
        begin
            a = action_t'($urandom_range(3));
            if ($urandom_range(9) == 0)
                k = $urandom();
            else if ($urandom_range(30) == 0)
                k = 32'd0;
            else
                k = pick_key();
            // Favor blocks so that queues grow deep.
            if ($urandom_range(2) == 0)
                a = ACT_BLOCK;
            send_beat(a, k, 5'($urandom()));
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = '0;
        sem_key = '0;
        proc_id = '0;
        out_stall = 1'b0;
        hold_off = 1'b0;
        idle_pct = 8;
        error_count = 0;
        cycle_count = 0;
        for (int i = 0; i < NPROC; i++)
            waits_on[i] = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
            tbl_used[i] = 0;
        for (int i = 0; i < 8; i++)
            key_pool[i] = $urandom() | 32'h1;
        key_pool[0] = 32'hFFFF_FFFF;
        key_pool[1] = 32'h0000_0001;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_table_full();
        test_backpressure();
        test_random(700, 8);
        test_random(300, 0);
        test_random(350, 8);

        if (error_count == 0)
            $display("semaphore_blocked_queue_table_unit_tb: clean");
        else
            $display("semaphore_blocked_queue_table_unit_tb: errors");
        $finish;
    end
endmodule
